FILE: rtl/sha256_byte_stream_hasher_unit_assert.svh
// Assertion macros used by the hasher core.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// Whenever the condition holds, the consequence holds in the same cycle.
`define SHB_ASSERT_IMPL(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("assertion failed");

// Whenever the condition holds, the consequence holds in the next cycle.
`define SHB_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("assertion failed");

`endif

FILE: rtl/shb_pkg.sv
package shb_pkg;

   typedef struct packed {
      logic       op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   typedef logic [31:0] word_type;

   function automatic word_type round_k(input logic [5:0] r);
      word_type k;
      case (r)
         6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
         6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
         6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
         6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
         6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
         6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
         6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
         6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
         6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
         6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
         6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
         6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
         default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   function automatic word_type initial_hash(input logic [2:0] i);
      word_type h;
      case (i)
         3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         default: h = 32'h5be0cd19;
      endcase
      return h;
   endfunction

   function automatic word_type ror32(input word_type x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

FILE: rtl/sha256_byte_stream_hasher_unit.sv
// SHA-256 hasher over a byte stream.
// The req_ channel carries one beat per item: op = absorb appends data_byte to
// the current 64-byte block, op = finish pads the message, appends its bit
// length and starts the digest output.
// The rsp_ channel carries eight beats after each finish, digest word 0 first,
// with last set on word 7. The chain value then returns to the initial hash.
// A small queue at the front takes request beats while the compression core
// is busy, so the sender sees stall only when that queue is full.
// An absorb byte is taken while the core is idle; the 64th byte of a block
// then runs the round loop, one round a cycle, and the chain update before
// the core takes the next byte. A finish runs the padding step, the round
// loop and the chain update, twice when 56 or more bytes were buffered, then
// sends eight beats, one per cycle while rsp_stall is low.
// A stall on rsp_ holds the current word; the core and the queue wait.
// Reset (synchronous, active high) empties the queue and clears the byte and
// bit counts and loads the initial hash values.
module sha256_byte_stream_hasher_unit #(
   parameter int QUEUE_DEPTH = shb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  shb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output shb_pkg::rsp_type rsp_data
);
   import shb_pkg::*;

   req_type q_data;
   logic    q_valid;
   logic    q_stall;

   shb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_stall (req_stall),
      .push_data  (req_data),
      .pop_valid  (q_valid),
      .pop_stall  (q_stall),
      .pop_data   (q_data)
   );

   shb_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (q_valid),
      .item_stall (q_stall),
      .item_data  (q_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/shb_queue.sv
module shb_queue #(
   parameter int DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_stall,
   input  shb_pkg::req_type push_data,
   output logic            pop_valid,
   input  logic            pop_stall,
   output shb_pkg::req_type pop_data
);
   import shb_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   req_type           mem_ff [DEPTH];
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [AW:0]       count_ff, count_in;
   logic              do_push, do_pop;

   assign push_stall = (count_ff == (AW+1)'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      count_in = count_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/shb_core.sv
module shb_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   output logic             item_stall,
   input  shb_pkg::req_type item_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output shb_pkg::rsp_type rsp_data
);
   import shb_pkg::*;

`include "sha256_byte_stream_hasher_unit_assert.svh"

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]  state_ff, state_in;
   word_type    chain_ff [8];
   word_type    v_ff [8];
   word_type    w_ff [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff;
   logic [5:0]  round_ff;
   logic        final_ff;
   logic        extra_ff;
   logic [63:0] total_ff;
   logic [2:0]  emit_ff;
   logic        accept;
   word_type    wt, s0, s1, ch, mj, t1, t2, ws0, ws1, wnew;

   assign item_stall = (state_ff != ST_IDLE);
   assign accept     = item_valid && !item_stall;

   assign rsp_valid            = (state_ff == ST_EMIT);
   assign rsp_data.digest_word = chain_ff[emit_ff];
   assign rsp_data.word_index  = emit_ff;
   assign rsp_data.last        = (emit_ff == 3'd7);

   // The 16-word window holds the schedule; w_ff[0] is the word of this round.
   always_comb begin
      wt   = w_ff[0];
      ws0  = ror32(w_ff[1], 7) ^ ror32(w_ff[1], 18) ^ (w_ff[1] >> 3);
      ws1  = ror32(w_ff[14], 17) ^ ror32(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = ws1 + w_ff[9] + ws0 + w_ff[0];
      s1   = ror32(v_ff[4], 6) ^ ror32(v_ff[4], 11) ^ ror32(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + s1 + ch + round_k(round_ff) + wt;
      s0   = ror32(v_ff[0], 2) ^ ror32(v_ff[0], 13) ^ ror32(v_ff[0], 22);
      mj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = s0 + mj;
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (item_data.op == OP_ABSORB) begin
                  fill_in = fill_ff + 6'd1;
                  if (fill_ff == 6'd63) begin
                     state_in = ST_ROUND;
                  end
               end else begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD:   state_in = ST_ROUND;
         ST_ROUND: if (round_ff == 6'd63) state_in = ST_ADD;
         ST_ADD: begin
            if (extra_ff) state_in = ST_PAD;
            else if (final_ff) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT: begin
            if (!rsp_stall && emit_ff == 3'd7) begin
               state_in = ST_IDLE;
               fill_in  = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         bits_ff  <= '0;
         round_ff <= '0;
         final_ff <= 1'b0;
         extra_ff <= 1'b0;
         emit_ff  <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= initial_hash(3'(i));
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         case (state_ff)
            ST_IDLE: begin
               round_ff <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
               if (accept && item_data.op == OP_ABSORB) begin
                  w_ff[fill_ff[5:2]] <= (w_ff[fill_ff[5:2]] & ~(32'hff000000 >>
                     (8 * fill_ff[1:0]))) | ({item_data.data_byte, 24'h0} >> (8 * fill_ff[1:0]));
                  final_ff <= 1'b0;
                  extra_ff <= 1'b0;
               end else if (accept) begin
                  // Finish: lay 0x80 over the byte after the last one, zero the rest.
                  total_ff <= bits_ff + {55'h0, fill_ff, 3'b000};
                  final_ff <= 1'b1;
                  extra_ff <= (fill_ff >= 6'd56);
                  for (int j = 0; j < 16; j++) begin
                     for (int b = 0; b < 4; b++) begin
                        if (6'(4 * j + b) == fill_ff) w_ff[j][31-8*b -: 8] <= 8'h80;
                        else if (6'(4 * j + b) > fill_ff) w_ff[j][31-8*b -: 8] <= 8'h00;
                     end
                  end
               end
            end
            ST_PAD: begin
               round_ff <= '0;
               for (int i = 0; i < 8; i++) v_ff[i] <= chain_ff[i];
               if (!extra_ff) begin
                  w_ff[14] <= total_ff[63:32];
                  w_ff[15] <= total_ff[31:0];
               end
            end
            ST_ROUND: begin
               round_ff <= round_ff + 6'd1;
               for (int j = 0; j < 15; j++) w_ff[j] <= w_ff[j+1];
               w_ff[15] <= wnew;
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + v_ff[i];
               if (extra_ff) begin
                  // Second padding block is all zeros but the length.
                  extra_ff <= 1'b0;
                  for (int j = 0; j < 16; j++) w_ff[j] <= '0;
               end else if (!final_ff) begin
                  bits_ff <= bits_ff + 64'd512;
               end
               emit_ff <= '0;
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  emit_ff <= emit_ff + 3'd1;
                  if (emit_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) chain_ff[i] <= initial_hash(3'(i));
                     bits_ff  <= '0;
                     final_ff <= 1'b0;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   `SHB_ASSERT_IMPL(a_emit_final, clock, reset, rsp_valid, final_ff)
   `SHB_ASSERT_NEXT(a_round_wrap, clock, reset, state_ff == ST_ROUND && round_ff == 6'd63,
      state_ff == ST_ADD)
   `SHB_ASSERT_NEXT(a_last_idle, clock, reset, rsp_valid && !rsp_stall && rsp_data.last,
      state_ff == ST_IDLE && fill_ff == 6'd0)

endmodule

FILE: tb/sha256_digest_checker.sv
`timescale 1ns / 100ps

module sha256_digest_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  shb_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  shb_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               words_pending
);
   import shb_pkg::*;

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [5:0]  byte_fill;
   logic [63:0] bit_total;
   rsp_type     digest_queue [$];

   function automatic logic [31:0] rot(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic run_rounds();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] t1, t2;
      for (int r = 0; r < 16; r++)
         w[r] = {msg_block[4*r], msg_block[4*r+1], msg_block[4*r+2], msg_block[4*r+3]};
      for (int r = 16; r < 64; r++)
         w[r] = (rot(w[r-2], 17) ^ rot(w[r-2], 19) ^ (w[r-2] >> 10)) + w[r-7]
              + (rot(w[r-15], 7) ^ rot(w[r-15], 18) ^ (w[r-15] >> 3)) + w[r-16];
      v = hash_state;
      for (int r = 0; r < 64; r++) begin
         t1 = v[7] + (rot(v[4], 6) ^ rot(v[4], 11) ^ rot(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[r] + w[r];
         t2 = (rot(v[0], 2) ^ rot(v[0], 13) ^ rot(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   task automatic absorb_beat(input req_type item);
      logic [63:0] length;
      int          pos;
      rsp_type     word;
      if (item.op == OP_ABSORB) begin
         msg_block[byte_fill] = item.data_byte;
         byte_fill++;
         if (byte_fill == 0) begin
            run_rounds();
            bit_total += 64'd512;
         end
         return;
      end
      length = bit_total + 64'(byte_fill) * 8;
      pos = int'(byte_fill);
      msg_block[6'(pos)] = 8'h80;
      pos++;
      if (pos > 56) begin
         while (pos < 64) begin
            msg_block[6'(pos)] = 8'h00;
            pos++;
         end
         run_rounds();
         pos = 0;
      end
      while (pos < 56) begin
         msg_block[6'(pos)] = 8'h00;
         pos++;
      end
      for (int i = 0; i < 8; i++) msg_block[56+i] = length[63-8*i -: 8];
      run_rounds();
      for (int i = 0; i < 8; i++) begin
         word.digest_word = hash_state[i];
         word.word_index  = 3'(i);
         word.last        = (i == 7);
         digest_queue.push_back(word);
      end
      hash_state = START_HASH;
      byte_fill = 0;
      bit_total = 0;
   endtask

   assign words_pending = digest_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         hash_state = START_HASH;
         byte_fill = 0;
         bit_total = 0;
         digest_queue.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) absorb_beat(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (digest_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected digest beat %h", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = digest_queue.pop_front();
               if (want !== rsp_data) begin
                  if (fail_count < 10)
                     $display("digest mismatch: expected %h/%0d/%b got %h/%0d/%b",
                        want.digest_word, want.word_index, want.last,
                        rsp_data.digest_word, rsp_data.word_index, rsp_data.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import shb_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      words_pending;
   bit      stimulus_done = 1'b0;

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   sha256_byte_stream_hasher_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));

   // The checker sees every accepted beat on both channels and keeps the
   // digest words still owed by the block.
   sha256_digest_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .words_pending(words_pending));

   // Sends one beat after a random gap, possibly none. Valid stays high
   // from beat to beat when the gap is zero, so it is never dropped and
   // raised in the same step.
   task automatic send_beat(input logic op, input logic [7:0] value);
      int gap;
      gap = $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op: op, data_byte: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_message(input int length, input bit random_bytes);
      for (int i = 0; i < length; i++)
         send_beat(OP_ABSORB, random_bytes ? 8'($urandom) : 8'(i));
      send_beat(OP_FINISH, 8'($urandom));
   endtask

   // The receiver raises a stall of random length, possibly none, before each
   // digest beat. Some stretches run with no stall at all.
   initial begin
      int hold;
      int calm;
      calm = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (calm > 0) begin
            calm--;
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 40) == 0) begin
            calm = 60;
            rsp_stall <= 1'b0;
         end else begin
            hold = $urandom_range(0, 3);
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
            end
            rsp_stall <= 1'b0;
            @(posedge clock);
            while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         end
      end
   end

   initial begin
      int sent;
      int len;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the empty message, finish with odd data bytes,
      // byte extremes, and messages around the padding boundary.
      send_beat(OP_FINISH, 8'hff);
      send_beat(OP_ABSORB, 8'h00);
      send_beat(OP_ABSORB, 8'hff);
      send_beat(OP_ABSORB, 8'h55);
      send_beat(OP_ABSORB, 8'haa);
      send_beat(OP_FINISH, 8'h00);

      // Hold off until every digest word has come back.
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);

      // Lengths 55, 56 and 64 hit the one- versus two-block padding and
      // the full-block compress right before finish.
      send_message(55, 1'b1);
      send_message(56, 1'b1);
      send_message(64, 1'b0);

      // Random part: short messages until about 220 beats have gone out.
      sent = 184;
      while (sent < 220) begin
         len = $urandom_range(0, 20);
         send_message(len, 1'b1);
         sent += len + 1;
      end
      req_valid <= 1'b0;
      stimulus_done = 1'b1;
   end

   // Final verdict once every expected digest word has arrived.
   initial begin
      wait (stimulus_done);
      while (words_pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0)
         $display("sha256_byte_stream_hasher_unit test passed");
      else
         $display("sha256_byte_stream_hasher_unit test failed");
      $finish;
   end

   // Timeout far beyond the slowest correct run.
   initial begin
      #4000000;
      $display("sha256_byte_stream_hasher_unit test failed");
      $finish;
   end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/shb_pkg.sv
rtl/shb_queue.sv
rtl/shb_core.sv
rtl/sha256_byte_stream_hasher_unit.sv
tb/sha256_digest_checker.sv
tb/tb.sv
